// ===== hdl/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern search core.
// Used by every module and by the channel interfaces; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  localparam int PAT_BYTES   = 16;
  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int LEN_W       = 5;
  localparam int CNT_W       = 32;
  localparam int ADDR_W      = 64;
  localparam int DATA_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int MASK_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_CARE    = 3'd2,
    CFG_LEN     = 3'd3,
    CFG_BASE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] pat_hi;
    logic [DATA_W-1:0] pat_lo;
    logic [MASK_W-1:0] care;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] base;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/mbps_ifs.sv =====
// Valid/ready channel interfaces for input bytes and search results.
// Depends on mbps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mbps_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [mbps_pkg::ADDR_W-1:0] match_address;
  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

`default_nettype wire

// ===== hdl/mbps_cfg_regs.sv =====
// Configuration register file: pattern, care mask, length and base address.
// Depends on mbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_hi <= '0;
      cfg_r.pat_lo <= '0;
      cfg_r.care   <= '1;
      cfg_r.len    <= '0;
      cfg_r.base   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAT_LO: cfg_r.pat_lo <= cfg_wdata;
        CFG_PAT_HI: cfg_r.pat_hi <= cfg_wdata;
        CFG_CARE:   cfg_r.care   <= cfg_wdata[MASK_W-1:0];
        CFG_LEN:    cfg_r.len    <= cfg_wdata[LEN_W-1:0];
        CFG_BASE:   cfg_r.base   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/mbps_window_match.sv =====
// Sliding byte window, region byte count and parallel masked compare.
// Depends on mbps_pkg; one byte is consumed per step.
`timescale 1ns / 1ps
`default_nettype none

module mbps_window_match
  import mbps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WIN_DEPTH);

  logic [WIN_DEPTH-1:0][7:0] win_r;
  logic [WIN_DEPTH-1:0][7:0] win_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_nxt;
  logic                      reported_r;
  logic [PAT_BYTES-1:0][7:0] pat;
  logic                      hit;
  logic [CNT_W-1:0]          offset;
  logic [ADDR_W-1:0]         addr;

  assign pat = {cfg.pat_hi, cfg.pat_lo};

  // Newest byte enters at index 0.
  assign win_nxt = {win_r[WIN_DEPTH-2:0], item.data_byte};
  assign cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    logic [LEN_W-1:0] k;
    k   = '0;
    hit = (cfg.len != '0) && (cfg.len <= LEN_MAX) &&
          (cnt_nxt >= CNT_W'(cfg.len));
    for (int j = 0; j < WIN_DEPTH; j++) begin
      k = cfg.len - LEN_W'(j) - LEN_W'(1);
      if ((LEN_W'(j) < cfg.len) && cfg.care[j] &&
          (win_nxt[k[WIN_IDX_W-1:0]] != pat[j])) begin
        hit = 1'b0;
      end
    end
  end

  assign offset = cnt_nxt - CNT_W'(cfg.len);
  assign addr   = cfg.base + ADDR_W'(offset);

  assign res_valid         = step && !reported_r && (hit || item.last_byte);
  assign res.found         = hit;
  assign res.match_address = hit ? addr : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      cnt_r      <= '0;
      reported_r <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        // region ends: drop window and count
        win_r      <= '0;
        cnt_r      <= '0;
        reported_r <= 1'b0;
      end else if (!reported_r) begin
        win_r <= win_nxt;
        cnt_r <= cnt_nxt;
        if (hit) begin
          reported_r <= 1'b1;
        end
      end
    end
  end

  a_hit_sets_reported: assert property (@(posedge clk) disable iff (!rst_n)
    step && !reported_r && hit && !item.last_byte |=> reported_r)
    else $error("match did not latch reported flag");

  a_no_result_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    step && reported_r |-> !res_valid)
    else $error("result emitted after match in same region");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> (cnt_r == '0) && !reported_r)
    else $error("region state not cleared on last byte");

endmodule

`default_nettype wire

// ===== hdl/masked_byte_pattern_search_core.sv =====
// Top level of the masked byte pattern search: input register, window/compare
// stage, result register. Depends on mbps_pkg, mbps_ifs, mbps_cfg_regs and
// mbps_window_match.
//
//  Channel   Dir  Handshake        Beat payload
//  in_ch     in   valid / ready    data_byte[7:0], last_byte
//  out_ch    out  valid / ready    found, match_address[63:0]
//  cfg_*     in   cfg_we only      cfg_index[2:0], cfg_wdata[63:0]
//
// One byte is accepted per cycle while the input register is empty or moving;
// a result beat is made only for a match or the last byte of a region.
// The window shift and the 16 parallel byte compares set the stage delay.
// Synchronous active-low reset loads register reset values and clears state.
// A stalled result register holds the compare stage; the input register
// keeps taking a beat while it is empty or moving.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_search_core
  import mbps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  mbps_in_if.sink                   in_ch,
  mbps_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata
);

  cfg_t  cfg;
  logic  s1_v_r;
  item_t s1_item_r;
  logic  out_v_r;
  res_t  out_res_r;
  logic  advance;
  logic  step;
  logic  res_valid;
  res_t  res;

  mbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance     = !out_v_r || out_ch.ready;
  assign step        = s1_v_r && advance;
  assign in_ch.ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.data_byte <= in_ch.data_byte;
      s1_item_r.last_byte <= in_ch.last_byte;
    end
  end

  mbps_window_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.found         = out_res_r.found;
  assign out_ch.match_address = out_res_r.match_address;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_v_r) && out_v_r |-> $past(step))
    else $error("result appeared without a processed beat");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ch.ready |=> s1_v_r)
    else $error("input register dropped a beat during stall");

endmodule

`default_nettype wire
